>>> src/frm_pkg.sv
package frm_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int TIME_W          = 32;
	localparam int WIN_W           = 31;
	localparam logic [WIN_W-1:0] WIN_RESET = 31'd65536;

	typedef struct packed {
		logic accept;
		logic push;
		logic read;
		logic span;
		logic clear;
		logic rate_max;
		logic div_start;
		logic rate_div;
		logic drop;
		logic rebase;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic span_neg;
		logic span_zero;
		logic span_gt_win;
		logic prune_drop;
		logic div_done;
	} sts_t;

endpackage

>>> src/frm_div.sv
module frm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [frm_pkg::TIME_W-1:0]   num,
	input  logic [frm_pkg::TIME_W-1:0]   den,
	output logic [frm_pkg::TIME_W-1:0]   quo,
	output logic                         done
);

	localparam int W  = frm_pkg::TIME_W;
	localparam int NW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          sat_q;
	logic [W:0]    shifted;
	logic          qbit;
	logic [W:0]    diff;

	// restoring division, numerator < divisor (quotient saturates otherwise), one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, 1'b0};
		qbit    = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
			sat_q <= num >= den;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], qbit};
		end
	end

	assign quo  = sat_q ? '1 : quo_q;
	assign done = done_q;

endmodule

>>> src/frm_ctrl.sv
module frm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  frm_pkg::sts_t sts,
	output frm_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH,
		ST_READ,
		ST_SPAN,
		ST_CHECK,
		ST_DIV,
		ST_PRUNE,
		ST_PRUNE_RD,
		ST_REBASE,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.accept = in_valid;
			ST_PUSH:     cmd.push = 1'b1;
			ST_READ:     cmd.read = 1'b1;
			ST_SPAN:     cmd.span = 1'b1;
			ST_CHECK: begin
				if (sts.span_neg) begin
					cmd.clear = 1'b1;
				end else if (sts.span_zero) begin
					cmd.rate_max = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			ST_DIV:      cmd.rate_div = sts.div_done;
			ST_PRUNE:    cmd.drop = sts.prune_drop;
			ST_PRUNE_RD: cmd.read = 1'b1;
			ST_REBASE:   cmd.rebase = 1'b1;
			ST_OUT:      cmd.out_load = out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_PUSH;
				end
				ST_PUSH:  state_q <= ST_READ;
				ST_READ:  state_q <= ST_SPAN;
				ST_SPAN:  state_q <= ST_CHECK;
				ST_CHECK: begin
					if (sts.span_neg) begin
						state_q <= ST_OUT;
					end else if (sts.span_zero) begin
						state_q <= sts.span_gt_win ? ST_PRUNE : ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_done) state_q <= sts.span_gt_win ? ST_PRUNE : ST_OUT;
				end
				ST_PRUNE: begin
					state_q <= sts.prune_drop ? ST_PRUNE_RD : ST_REBASE;
				end
				ST_PRUNE_RD: state_q <= ST_PRUNE;
				ST_REBASE:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("pending word overwritten");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled word dropped");

	a_accept_push: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_PUSH)
		else $error("accepted word not pushed");
`endif

endmodule

>>> src/frm_dp.sv
module frm_dp #(
	parameter  int STORE_DEPTH = frm_pkg::STORE_DEPTH_DEF,
	localparam int AW = $clog2(STORE_DEPTH),
	localparam int CW = $clog2(STORE_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  frm_pkg::cmd_t                     cmd,
	output frm_pkg::sts_t                     sts,
	input  logic                              cfg_we,
	input  logic [frm_pkg::WIN_W-1:0]         cfg_wdata,
	input  logic signed [frm_pkg::TIME_W-1:0] frame_time,
	output logic [frm_pkg::TIME_W-1:0]        rate,
	output logic [CW-1:0]                     stored_count,
	output logic                              window_cleared
);

	localparam int W  = frm_pkg::TIME_W;
	localparam int WW = frm_pkg::WIN_W;

	// entries are kept raw; logical value = raw - off_q (mod 2^32)
	logic [W-1:0]        store_q [STORE_DEPTH];
	logic [AW-1:0]       ptr_q;
	logic [CW-1:0]       count_q;
	logic [W-1:0]        tp_q;
	logic [W-1:0]        off_q;
	logic [W-1:0]        last_rate_q;
	logic [WW-1:0]       win_q;
	logic                cleared_q;
	logic [W-1:0]        dt_q;
	logic [W-1:0]        rd_q;
	logic [W:0]          span_q;
	logic signed [W+1:0] stamp_q;
	logic [W-1:0]        rate_q;
	logic [CW-1:0]       count_out_q;
	logic                cleared_out_q;

	logic          full;
	logic [W:0]    pos_sum;
	logic [W-1:0]  pos;
	logic          we;
	logic [AW-1:0] waddr;
	logic [W-1:0]  wdata;
	logic [W-1:0]  oldest;
	logic [W:0]    span_c;
	logic [W+1:0]  stamp_c;
	logic          base_pos;
	logic [AW-1:0] ptr_inc;
	logic [W-1:0]  div_quo;
	logic          div_done;

	function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [CW-1:0] k);
		logic [CW:0] s;
		s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, k};
		if (s >= (CW + 1)'(STORE_DEPTH)) s = s - (CW + 1)'(STORE_DEPTH);
		return s[AW-1:0];
	endfunction

	always_comb begin
		full    = count_q == CW'(STORE_DEPTH);
		ptr_inc = slot_add(ptr_q, CW'(1));
		pos_sum = {tp_q[W-1], tp_q} + {dt_q[W-1], dt_q};
		if (pos_sum[W] != pos_sum[W-1]) begin
			pos = pos_sum[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
		end else begin
			pos = pos_sum[W-1:0];
		end
		we    = (cmd.accept && count_q == '0) || cmd.push;
		waddr = cmd.accept ? '0 : (full ? ptr_q : slot_add(ptr_q, count_q));
		wdata = cmd.accept ? off_q : pos + off_q;

		oldest   = rd_q - off_q;
		span_c   = {tp_q[W-1], tp_q} - {oldest[W-1], oldest};
		stamp_c  = {{2{tp_q[W-1]}}, tp_q} - {{(W + 2 - WW){1'b0}}, win_q};
		base_pos = !oldest[W-1] && oldest != '0;

		sts.span_neg    = span_q[W];
		sts.span_zero   = span_q == '0;
		sts.span_gt_win = !span_q[W] && span_q[W-1:0] > {{(W - WW){1'b0}}, win_q};
		sts.prune_drop  = count_q > CW'(1)
			&& $signed({{2{oldest[W-1]}}, oldest}) < stamp_q;
		sts.div_done    = div_done;
	end

	frm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (W'(count_q)),
		.den    (span_q[W-1:0]),
		.quo    (div_quo),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			count_q     <= '0;
			tp_q        <= '0;
			off_q       <= '0;
			last_rate_q <= '0;
			win_q       <= frm_pkg::WIN_RESET;
			cleared_q   <= 1'b0;
		end else begin
			if (cfg_we) win_q <= cfg_wdata;
			if (cmd.accept) begin
				cleared_q <= 1'b0;
				if (count_q == '0) begin
					ptr_q   <= '0;
					count_q <= CW'(1);
				end
			end
			if (cmd.push) begin
				tp_q <= pos;
				if (full) begin
					ptr_q <= ptr_inc;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.clear) begin
				count_q   <= '0;
				ptr_q     <= '0;
				tp_q      <= '0;
				cleared_q <= 1'b1;
			end
			if (cmd.rate_max) last_rate_q <= '1;
			if (cmd.rate_div) last_rate_q <= div_quo;
			if (cmd.drop) begin
				ptr_q   <= ptr_inc;
				count_q <= count_q - CW'(1);
			end
			if (cmd.rebase && base_pos) begin
				off_q <= off_q + oldest;
				tp_q  <= tp_q - oldest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) store_q[waddr] <= wdata;
		if (cmd.read) rd_q <= store_q[ptr_q];
		if (cmd.accept) dt_q <= frame_time;
		if (cmd.span) begin
			span_q  <= span_c;
			stamp_q <= $signed(stamp_c);
		end
		if (cmd.out_load) begin
			rate_q        <= last_rate_q;
			count_out_q   <= count_q;
			cleared_out_q <= cleared_q;
		end
	end

	assign rate           = rate_q;
	assign stored_count   = count_out_q;
	assign window_cleared = cleared_out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STORE_DEPTH))
		else $error("timestamp count above depth");

	a_drop_keeps_newest: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> count_q > CW'(1))
		else $error("prune would drop newest timestamp");

	a_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> count_q != '0)
		else $error("store empty after accept");
`endif

endmodule

>>> src/sliding_window_frame_rate_meter.sv
// Sliding-window frame rate meter. Each input word is one frame's elapsed time (signed
// Q16.16 s); each produces one output word with the rate (unsigned Q16.16 frames/s), the
// number of timestamps held and a flag set when a negative span emptied the store. One
// word is processed at a time, and the next is accepted only once the last is through;
// the rate uses the 32-step serial divider unless the span is zero or negative. When
// the span exceeds the window, the walk over the single-port timestamp memory takes a
// check and a read per timestamp dropped, then a final window check and the rebase,
// which needs no memory pass since entries are stored relative to an offset register. No
// clearing pass follows reset. A finished word waits in the output register while the
// next input is accepted; output stalls hold the block until the pending word is taken.
// window_length must only be written while the block is idle.
module sliding_window_frame_rate_meter #(
	parameter  int STORE_DEPTH = frm_pkg::STORE_DEPTH_DEF,
	localparam int CW = $clog2(STORE_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [frm_pkg::WIN_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [frm_pkg::TIME_W-1:0] frame_time,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [frm_pkg::TIME_W-1:0]        rate,
	output logic [CW-1:0]                     stored_count,
	output logic                              window_cleared
);

	frm_pkg::cmd_t cmd;
	frm_pkg::sts_t sts;

	frm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	frm_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.frame_time     (frame_time),
		.rate           (rate),
		.stored_count   (stored_count),
		.window_cleared (window_cleared)
	);

endmodule
